// ===== rtl/fan_direction_generator_macros.svh =====
// Assertion macros used by the fan direction generator module.
`ifndef FAN_DIRECTION_GENERATOR_MACROS_SVH
`define FAN_DIRECTION_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDG_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fan direction generator check failed");
`define FDG_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("fan direction generator reset check failed");
`else
`define FDG_ASSERT(lbl, prop)
`define FDG_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/fdg_pkg.sv =====
package fdg_pkg;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 7;
   localparam int VEC_W = 28;
   localparam int SQ_W = 56;
   localparam int LEN_W = 28;
   localparam int NUM_W = 42;
   localparam int DEN_W = 28;
   localparam int Q_W = 16;
   localparam int CS_W = 32;
   localparam int Z_W = 33;
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 32;
   localparam int PROD_W = 60;
   localparam int ACC_W = 48;
   localparam int CORDIC_STEPS = 16;
   localparam int UNIT_SHIFT = 14;
   localparam logic [Q_W-1:0] UNIT_ONE = 16'd16384;
   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;
   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };
endpackage

// ===== rtl/fdg_div.sv =====
module fdg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fdg_pkg::NUM_W-1:0] num,
   input  logic [fdg_pkg::DEN_W-1:0] den,
   output logic                      done,
   output logic [fdg_pkg::Q_W-1:0]   quotient
);
   import fdg_pkg::*;

   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [$clog2(Q_W)-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]         rem_ff, rem_in, den_ff, den_in;
   logic [Q_W-1:0]           quo_ff, quo_in;
   logic [DEN_W:0]           trial;
   logic                     ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      trial = {rem_ff, quo_ff[Q_W-1]};
      ge = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = DEN_W'(num >> Q_W);
         quo_in = num[Q_W-1:0];
         den_in = den;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == $clog2(Q_W)'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/fdg_sqrt.sv =====
module fdg_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [fdg_pkg::SQ_W-1:0] radicand,
   output logic                     done,
   output logic [fdg_pkg::LEN_W-1:0] root
);
   import fdg_pkg::*;

   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [$clog2(LEN_W)-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]          rad_ff, rad_in;
   logic [LEN_W:0]           rem_ff, rem_in;
   logic [LEN_W-1:0]         root_ff, root_in;
   logic [LEN_W+2:0]         cur, trial;
   logic                     ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cur = {rem_ff, rad_ff[SQ_W-1:SQ_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      ge = cur >= trial;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? (LEN_W+1)'(cur - trial) : cur[LEN_W:0];
         root_in = {root_ff[LEN_W-2:0], ge};
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == $clog2(LEN_W)'(LEN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/fdg_cordic.sv =====
module fdg_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fdg_pkg::FIELD_W-1:0]       angle,
   output logic                              done,
   output logic signed [fdg_pkg::CS_W-1:0]   cos_out,
   output logic signed [fdg_pkg::CS_W-1:0]   sin_out
);
   import fdg_pkg::*;

   logic                            busy_ff, busy_in, done_ff, done_in;
   logic                            flip_ff, flip_in;
   logic [$clog2(CORDIC_STEPS)-1:0] iter_ff, iter_in;
   logic signed [CS_W-1:0]          x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [CS_W-1:0]          cos_ff, cos_in, sin_ff, sin_in;
   logic signed [Z_W-1:0]           z_ff, z_in, atan;
   logic [FIELD_W-1:0]              turned, folded;
   logic                            flip;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      turned = angle + 16'h4000;
      flip = turned[FIELD_W-1];
      folded = flip ? angle + 16'h8000 : angle;
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      atan = Z_W'(ATAN_TAB[iter_ff]);
      if (start) begin
         busy_in = 1'b1;
         flip_in = flip;
         iter_in = '0;
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = {folded[FIELD_W-1], folded, 16'h0000};
      end else if (busy_ff) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == $clog2(CORDIC_STEPS)'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in = flip_ff ? -x_in : x_in;
            sin_in = flip_ff ? -y_in : y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign done = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

// ===== rtl/fan_direction_generator.sv =====
// Fan direction generator.
// An input transfer on the req_ channel carries a forward vector (Q2.14), a
// centre angle, a spread angle (65536 units per turn) and a count. The block
// answers with one rsp_ transfer per direction, the last one marked by
// rsp_last_dir; a count of zero gives no transfer at all, and a count above
// MAX_WAYS is treated as MAX_WAYS.
// Only one fan is handled at a time: req_ready is high only while the block
// is idle, and it rises again in the cycle after the last direction has been
// taken. The work is done by one multiplier, one CORDIC unit, one square
// root unit and one divider; the CORDIC unit, the square root unit and the
// divider each iterate one step per cycle. The right vector is normalised
// before the first direction; each direction then needs an offset division
// (none when the count is one), a CORDIC rotation, a square root and a
// division per component; the divisions and the square root dominate.
// When the receiver stalls, the direction is held on rsp_ until it is taken
// and no further work is done. A synchronous reset returns the block to
// idle with no direction pending.
`include "fan_direction_generator_macros.svh"
module fan_direction_generator #(
   parameter int MAX_WAYS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fdg_pkg::FIELD_W-1:0]    req_forward_x,
   input  logic signed [fdg_pkg::FIELD_W-1:0]    req_forward_y,
   input  logic signed [fdg_pkg::FIELD_W-1:0]    req_forward_z,
   input  logic signed [fdg_pkg::FIELD_W-1:0]    req_center_angle,
   input  logic [fdg_pkg::FIELD_W-1:0]           req_spread_angle,
   input  logic [fdg_pkg::COUNT_W-1:0]           req_way_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fdg_pkg::FIELD_W-1:0]    rsp_dir_x,
   output logic signed [fdg_pkg::FIELD_W-1:0]    rsp_dir_y,
   output logic signed [fdg_pkg::FIELD_W-1:0]    rsp_dir_z,
   output logic                                  rsp_last_dir
);
   import fdg_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_SQ        = 14'b00000000000010,
      ST_SQRT_GO   = 14'b00000000000100,
      ST_SQRT_WAIT = 14'b00000000001000,
      ST_DIV_GO    = 14'b00000000010000,
      ST_DIV_WAIT  = 14'b00000000100000,
      ST_NEND      = 14'b00000001000000,
      ST_OFF       = 14'b00000010000000,
      ST_OFF_GO    = 14'b00000100000000,
      ST_OFF_WAIT  = 14'b00001000000000,
      ST_CORD_GO   = 14'b00010000000000,
      ST_CORD_WAIT = 14'b00100000000000,
      ST_COMB      = 14'b01000000000000,
      ST_OUT       = 14'b10000000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [FIELD_W-1:0]  fwd_ff [3];
   logic signed [FIELD_W-1:0]  fwd_in [3];
   logic signed [FIELD_W-1:0]  rn_ff [3];
   logic signed [FIELD_W-1:0]  rn_in [3];
   logic signed [FIELD_W-1:0]  u_ff [3];
   logic signed [FIELD_W-1:0]  u_in [3];
   logic signed [VEC_W-1:0]    vec_ff [3];
   logic signed [VEC_W-1:0]    vec_in [3];
   logic [FIELD_W-1:0]         center_ff, center_in, spread_ff, spread_in;
   logic [FIELD_W-1:0]         ang_ff, ang_in;
   logic [COUNT_W-1:0]         n_ff, n_in, k_ff, k_in, n_sat;
   logic [2:0]                 idx_ff, idx_in;
   logic                       is_right_ff, is_right_in, neg_ff, neg_in;
   logic [SQ_W-1:0]            acc_ff, acc_in;
   logic signed [ACC_W-1:0]    dacc_ff, dacc_in, dsum, drnd;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic signed [CS_W-1:0]     cs_ff, cs_in, sn_ff, sn_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [7:0]          offk;
   logic [1:0]                 sel;
   logic [VEC_W-1:0]           vmag;
   logic [PROD_W-1:0]          pmag;
   logic [Q_W-1:0]             qsat;
   logic signed [16:0]         rx, ry, rz;
   logic                       near_axis;
   logic                       div_start, div_done, sqrt_start, sqrt_done;
   logic                       cord_start, cord_done;
   logic [NUM_W-1:0]           div_num;
   logic [DEN_W-1:0]           div_den;
   logic [Q_W-1:0]             div_q;
   logic [LEN_W-1:0]           root;
   logic signed [CS_W-1:0]     cord_cos, cord_sin;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_dir_x = u_ff[0];
   assign rsp_dir_y = u_ff[1];
   assign rsp_dir_z = u_ff[2];
   assign rsp_last_dir = (k_ff == n_ff - 1'b1);

   assign n_sat = (req_way_count > COUNT_W'(MAX_WAYS)) ? COUNT_W'(MAX_WAYS) : req_way_count;
   assign offk = 8'(k_ff) + 8'(k_ff) - 8'(n_ff - 1'b1);
   assign sel = idx_ff[1:0];
   assign vmag = vec_ff[sel] [VEC_W-1] ? VEC_W'(-vec_ff[sel]) : VEC_W'(vec_ff[sel]);
   assign pmag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign qsat = (div_q > UNIT_ONE) ? UNIT_ONE : div_q;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      case (state_ff)
         ST_SQ: begin
            if (idx_ff != 3'd3) begin
               mul_a = vec_ff[sel];
               mul_b = MUL_B_W'(vec_ff[sel]);
            end
         end
         ST_OFF: begin
            mul_a = MUL_A_W'(offk);
            mul_b = MUL_B_W'({1'b0, spread_ff});
         end
         ST_COMB: begin
            if (idx_ff < 3'd6) begin
               if (!idx_ff[0]) begin
                  mul_a = MUL_A_W'(fwd_ff[idx_ff[2:1]]);
                  mul_b = cs_ff;
               end else begin
                  mul_a = MUL_A_W'(rn_ff[idx_ff[2:1]]);
                  mul_b = sn_ff;
               end
            end
         end
         ST_DIV_GO: begin
            div_num = {vmag, {UNIT_SHIFT{1'b0}}} + NUM_W'(len_ff >> 1);
            div_den = len_ff;
         end
         ST_OFF_GO: begin
            div_num = NUM_W'(pmag) + NUM_W'(n_ff - 1'b1);
            div_den = DEN_W'({n_ff - 1'b1, 1'b0});
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      fwd_in = fwd_ff;
      rn_in = rn_ff;
      u_in = u_ff;
      vec_in = vec_ff;
      center_in = center_ff;
      spread_in = spread_ff;
      ang_in = ang_ff;
      n_in = n_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      is_right_in = is_right_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      dacc_in = dacc_ff;
      len_in = len_ff;
      cs_in = cs_ff;
      sn_in = sn_ff;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      cord_start = 1'b0;
      dsum = dacc_ff + ACC_W'(prod_ff);
      drnd = (dsum + ACC_W'(1 << 19)) >>> 20;
      near_axis = (req_forward_z >= -16'sd1) && (req_forward_z <= 16'sd1) &&
                  (req_forward_x >= -16'sd1) && (req_forward_x <= 16'sd1);
      rx = near_axis ? 17'sd0 : 17'(req_forward_z);
      ry = near_axis ? -17'(req_forward_z) : 17'sd0;
      rz = near_axis ? 17'(req_forward_y) : -17'(req_forward_x);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fwd_in[0] = req_forward_x;
               fwd_in[1] = req_forward_y;
               fwd_in[2] = req_forward_z;
               center_in = req_center_angle;
               spread_in = req_spread_angle;
               n_in = n_sat;
               vec_in[0] = VEC_W'(rx) <<< 10;
               vec_in[1] = VEC_W'(ry) <<< 10;
               vec_in[2] = VEC_W'(rz) <<< 10;
               is_right_in = 1'b1;
               idx_in = '0;
               acc_in = '0;
               if (n_sat != '0) begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            if (idx_ff != 3'd0) begin
               acc_in = acc_ff + prod_ff[SQ_W-1:0];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 3'd3) begin
               state_in = ST_SQRT_GO;
            end
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in = root;
               idx_in = '0;
               if (root == '0) begin
                  u_in[0] = '0;
                  u_in[1] = '0;
                  u_in[2] = '0;
                  state_in = ST_NEND;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               u_in[sel] = vec_ff[sel][VEC_W-1] ? FIELD_W'(-qsat) : FIELD_W'(qsat);
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff == 3'd2) ? ST_NEND : ST_DIV_GO;
            end
         end
         ST_NEND: begin
            if (is_right_ff) begin
               rn_in = u_ff;
               k_in = '0;
               state_in = ST_OFF;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OFF: begin
            if (n_ff == COUNT_W'(1)) begin
               ang_in = center_ff;
               state_in = ST_CORD_GO;
            end else begin
               state_in = ST_OFF_GO;
            end
         end
         ST_OFF_GO: begin
            div_start = 1'b1;
            neg_in = prod_ff[PROD_W-1];
            state_in = ST_OFF_WAIT;
         end
         ST_OFF_WAIT: begin
            if (div_done) begin
               ang_in = center_ff + (neg_ff ? -div_q : div_q);
               state_in = ST_CORD_GO;
            end
         end
         ST_CORD_GO: begin
            cord_start = 1'b1;
            state_in = ST_CORD_WAIT;
         end
         ST_CORD_WAIT: begin
            if (cord_done) begin
               cs_in = cord_cos;
               sn_in = cord_sin;
               idx_in = '0;
               dacc_in = '0;
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            if (idx_ff != 3'd0) begin
               if (!idx_ff[0]) begin
                  vec_in[idx_ff[2:1] - 2'd1] = VEC_W'(drnd);
                  dacc_in = '0;
               end else begin
                  dacc_in = dsum;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 3'd6) begin
               is_right_in = 1'b0;
               idx_in = '0;
               acc_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (k_ff == n_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_OFF;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      fwd_ff <= fwd_in;
      rn_ff <= rn_in;
      u_ff <= u_in;
      vec_ff <= vec_in;
      center_ff <= center_in;
      spread_ff <= spread_in;
      ang_ff <= ang_in;
      n_ff <= n_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      is_right_ff <= is_right_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      dacc_ff <= dacc_in;
      len_ff <= len_in;
      cs_ff <= cs_in;
      sn_ff <= sn_in;
      prod_ff <= prod_in;
   end

   fdg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   fdg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   fdg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (ang_ff),
      .done    (cord_done),
      .cos_out (cord_cos),
      .sin_out (cord_sin)
   );

   `FDG_ASSERT(a_one_side, rsp_valid |-> !req_ready)
   `FDG_ASSERT(a_last_frees, (rsp_valid && rsp_ready && rsp_last_dir) |=> req_ready)
   `FDG_ASSERT(a_more_follows, (rsp_valid && rsp_ready && !rsp_last_dir) |=> !req_ready)
   `FDG_ASSERT_RST(a_reset_idle, reset |=> (req_ready && !rsp_valid))
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   import fdg_pkg::*;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_forward_x = '0;
   logic signed [15:0] req_forward_y = '0;
   logic signed [15:0] req_forward_z = '0;
   logic signed [15:0] req_center_angle = '0;
   logic [15:0] req_spread_angle = '0;
   logic [6:0] req_way_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic rsp_last_dir;

   dir_type expected_dirs[$];
   int errors = 0;
   bit rx_idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   int hold_off_cycles = 0;

   fan_direction_generator uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #400_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void make_unit(input longint v[3], output longint o[3]);
      longint unsigned sq = 0, len, mag;
      for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
      len = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
         if (len == 0) begin
            o[i] = 0;
         end else begin
            mag = v[i] < 0 ? -v[i] : v[i];
            mag = (mag * 16384 + len / 2) / len;
            if (mag > 16384) mag = 16384;
            o[i] = v[i] < 0 ? -longint'(mag) : longint'(mag);
         end
      end
   endfunction

   function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                   output longint s);
      logic [15:0] a = ang;
      bit flip = ((a + 16'h4000) >= 16'h8000);
      longint x = 64'h26DD3B6A, y = 0, z, t;
      if (flip) a = a + 16'h8000;
      z = longint'($signed(a)) * 65536;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            t = x - asr(y, i);
            y = y + asr(x, i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            t = x + asr(y, i);
            y = y - asr(x, i);
            z += longint'(ATAN_TAB[i]);
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   task automatic predict_fan(input logic signed [15:0] fx, fy, fz, ca,
                              input logic [15:0] sp, input logic [6:0] cnt);
      longint f[3], r[3], rn[3], d[3], u[3];
      longint n, num, den, mag, off, cs, sn;
      dir_type e;
      f = '{fx, fy, fz};
      n = cnt > 64 ? 64 : cnt;
      if (n == 0) return;
      r = '{f[2], 0, -f[0]};
      if (r[0] * r[0] + r[2] * r[2] < 3) r = '{0, -f[2], f[1]};
      for (int j = 0; j < 3; j++) r[j] = r[j] * 1024;
      make_unit(r, rn);
      for (longint k = 0; k < n; k++) begin
         off = 0;
         if (n > 1) begin
            num = (2 * k - (n - 1)) * longint'(sp);
            den = 2 * (n - 1);
            mag = ((num < 0 ? -num : num) + den / 2) / den;
            off = num < 0 ? -mag : mag;
         end
         sin_cos(16'(longint'(ca) + off), cs, sn);
         for (int j = 0; j < 3; j++)
            d[j] = asr(f[j] * cs + rn[j] * sn + (64'd1 << 19), 20);
         make_unit(d, u);
         e.x = 16'(u[0]);
         e.y = 16'(u[1]);
         e.z = 16'(u[2]);
         e.last = (k == n - 1);
         expected_dirs = {expected_dirs, e};
      end
   endtask

   task automatic send_fan(input logic signed [15:0] fx, fy, fz, ca,
                           input logic [15:0] sp, input logic [6:0] cnt,
                           input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_forward_x <= fx;
      req_forward_y <= fy;
      req_forward_z <= fz;
      req_center_angle <= ca;
      req_spread_angle <= sp;
      req_way_count <= cnt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_fan(fx, fy, fz, ca, sp, cnt);
   endtask

   function automatic logic signed [15:0] rand_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic send_unit_fan(input logic [6:0] cnt, input bit gaps);
      int sel = $urandom_range(0, 4);
      int fx = 0, fy = 0, fz = 0;
      real th, ph;
      if (sel == 0) begin
         fx = rand_comp(); fy = rand_comp(); fz = rand_comp();
      end else if (sel == 1) begin
         fy = $urandom_range(0, 1) ? 16384 : -16384;
         fx = $urandom_range(0, 2) - 1;
         fz = $urandom_range(0, 2) - 1;
      end else begin
         th = $urandom_range(0, 62831) / 10000.0;
         ph = ($urandom_range(0, 31415) / 10000.0) - 1.5707;
         fx = int'(16384.0 * $cos(ph) * $cos(th));
         fy = int'(16384.0 * $sin(ph));
         fz = int'(16384.0 * $cos(ph) * $sin(th));
      end
      send_fan(16'(fx), 16'(fy), 16'(fz), 16'($urandom), 16'($urandom), cnt, gaps);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_dirs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_off_cycles <= 3000;
            rsp_ready <= 1'b0;
         end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            hold_off_cycles <= $urandom_range(1, 19);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dir_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dirs.size() == 0) begin
            $error("unexpected direction transfer");
            errors++;
         end else begin
            e = expected_dirs.pop_front();
            if (rsp_dir_x !== e.x) begin
               $error("dir_x expected %0d actual %0d", e.x, rsp_dir_x); errors++;
            end
            if (rsp_dir_y !== e.y) begin
               $error("dir_y expected %0d actual %0d", e.y, rsp_dir_y); errors++;
            end
            if (rsp_dir_z !== e.z) begin
               $error("dir_z expected %0d actual %0d", e.z, rsp_dir_z); errors++;
            end
            if (rsp_last_dir !== e.last) begin
               $error("last_dir expected %0d actual %0d", e.last, rsp_last_dir);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_fan(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd16384, 7'd1, 1'b0);
      send_fan(16'sd0, 16'sd0, 16'sd16384, 16'sh7FFF, 16'hFFFF, 7'd3, 1'b1);
      send_fan(16'sd0, 16'sd16384, 16'sd0, 16'sh8000, 16'h8000, 7'd5, 1'b1);
      send_fan(16'sd0, -16'sd16384, 16'sd0, 16'sd100, 16'h4000, 7'd4, 1'b1);
      send_fan(16'sd1, 16'sd16384, 16'sd1, 16'sd0, 16'h1000, 7'd2, 1'b1);
      send_fan(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h4000, 7'd3, 1'b1);
      send_fan(-16'sd16384, -16'sd16384, -16'sd16384, 16'sh4000, 16'd0, 7'd2, 1'b1);
      send_fan(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'h2000, 7'd0, 1'b1);
      send_fan(16'sd0, 16'sd0, -16'sd16384, -16'sd16384, 16'h0001, 7'd127, 1'b1);
      send_fan(16'sd11585, 16'sd0, 16'sd11585, 16'sh2000, 16'hAAAA, 7'd64, 1'b1);
      send_fan(-16'sd1, 16'sh5555, -16'sh2AAA, 16'sh5555, 16'h5555, 7'd65, 1'b1);
      send_fan(16'sh2AAA, -16'sh5556, 16'sh7FFF, -16'sh5556, 16'hAAAA, 7'h2A, 1'b1);
      send_fan(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'h0000, 7'h55, 1'b1);
      wait_drained();
   endtask

   task automatic test_random();
      for (int i = 0; i < 120; i++)
         send_unit_fan(7'($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 6)), 1'b1);
      wait_drained();
   endtask

   task automatic test_receiver_hold_off();
      @(posedge clock);
      long_hold_req = 1'b1;
      send_unit_fan(7'd6, 1'b0);
      send_unit_fan(7'd3, 1'b0);
      send_unit_fan(7'd2, 1'b0);
      wait_drained();
   endtask

   task automatic test_no_idling();
      rx_idle_on = 1'b0;
      for (int i = 0; i < 30; i++) send_unit_fan(7'($urandom_range(0, 5)), 1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_receiver_hold_off();
      test_random();
      test_no_idling();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fdg_pkg.sv
rtl/fdg_div.sv
rtl/fdg_sqrt.sv
rtl/fdg_cordic.sv
rtl/fan_direction_generator.sv
verif/tb_top.sv
